[hw/rtl/mqsb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_pkg: shared definitions for the multi-queue shared buffer
// Sizes, slot encoding, request and response formats, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  // Store geometry.
  localparam int SLOTS       = 16;
  localparam int QUEUES      = 4;
  localparam int DATA_WIDTH  = 32;

  // A slot number holds 0..SLOTS, where SLOTS itself means "no slot".
  localparam int SLOT_W      = $clog2(SLOTS + 1);
  localparam int SLOT_IDX_W  = $clog2(SLOTS);
  localparam int QUEUE_IDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(SLOTS);

  // Request opcodes.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         queue_id;
    logic signed [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic init_wr;  // write one free-list link during the clearing pass
    logic accept;   // take the request and issue the memory reads
    logic commit;   // finish the request and load the response register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic init_last;  // the clearing pass is at its last slot
    logic out_free;   // the response register can take a new response
  } dp_status_t;

  // True when a slot number points at a real slot.
  function automatic logic is_slot(input logic [SLOT_W-1:0] s);
    return s < SLOT_W'(SLOTS);
  endfunction

  // Reduce a queue number modulo QUEUES by repeated subtraction.
  function automatic logic [QUEUE_IDX_W-1:0] queue_sel(input logic [1:0] id);
    logic [8:0] r;
    r = 9'(id);
    for (int i = 0; i < 4; i++) begin
      if (r >= 9'(QUEUES)) begin
        r = r - 9'(QUEUES);
      end
    end
    return QUEUE_IDX_W'(r);
  endfunction

endpackage

[hw/rtl/multi_queue_shared_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: several FIFO queues in one shared slot store
// Queues are linked lists of slots; unused slots form a free list.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_ready, req) carries an enqueue of
//   data_in to queue queue_id, or a dequeue from queue queue_id. Every request
//   yields one response on (rsp_valid, rsp_ready, rsp): the dequeued word and
//   a status of ok, store full (enqueue) or queue empty (dequeue).
//   A request is taken in the cycle its memory reads are issued and finished
//   in its commit step, which loads the response register; the block takes
//   no new request until the last one is finished. That comes from the
//   read followed by the write of the link RAM for each request.
//   After reset a clearing pass, one link per slot, writes the free
//   list into the link RAM; req_ready stays low until it is done.
//   The response sits in an output register. When the receiver stalls, the
//   next request is still taken and its reads done, and it waits in its
//   commit step until the response register is free.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mqsb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mqsb_pkg::rsp_t rsp
);

  mqsb_pkg::dp_cmd_t    dp_cmd;
  mqsb_pkg::dp_status_t dp_stat;

  // Sequencer.
  mqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Pointers, stores and response register.
  mqsb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[hw/rtl/mqsb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/mqsb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_datapath: queue pointers, link and data stores, response register
// Holds the head and tail of every queue and the free-list head, drives the
// link and data RAMs, and builds the response of each request.
// ----------------------------------------------------------------------------
module mqsb_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  mqsb_pkg::dp_cmd_t      cmd,
  output mqsb_pkg::dp_status_t   stat,
  input  mqsb_pkg::req_t         req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output mqsb_pkg::rsp_t         rsp
);

  // Queue pointers and free-list head.
  logic [mqsb_pkg::SLOT_W-1:0] head_slot [mqsb_pkg::QUEUES];
  logic [mqsb_pkg::SLOT_W-1:0] tail_slot [mqsb_pkg::QUEUES];
  logic [mqsb_pkg::SLOT_W-1:0] free_head;

  // Clearing-pass counter.
  logic [mqsb_pkg::SLOT_IDX_W-1:0] init_cnt;

  // The request in flight.
  logic                             cur_cmd;
  logic [mqsb_pkg::QUEUE_IDX_W-1:0] cur_q;
  logic [mqsb_pkg::SLOT_W-1:0]      cur_slot;
  logic                             cur_ok;

  // Decode of the incoming request.
  logic [mqsb_pkg::QUEUE_IDX_W-1:0] req_q;
  logic [mqsb_pkg::SLOT_W-1:0]      req_head;
  logic [mqsb_pkg::SLOT_W-1:0]      req_tail;
  logic [mqsb_pkg::SLOT_W-1:0]      req_slot;
  logic                             req_ok;
  logic [mqsb_pkg::SLOT_IDX_W-1:0]  req_idx;

  // RAM ports.
  logic                             link_wr_en;
  logic [mqsb_pkg::SLOT_IDX_W-1:0]  link_wr_addr;
  logic [mqsb_pkg::SLOT_W-1:0]      link_wr_data;
  logic                             link_rd_en;
  logic [mqsb_pkg::SLOT_W-1:0]      link_rd_data;
  logic                             data_wr_en;
  logic                             data_rd_en;
  logic [mqsb_pkg::DATA_WIDTH-1:0]  data_wr_word;
  logic [mqsb_pkg::DATA_WIDTH-1:0]  data_rd_data;
  logic [63:0]                      word_in64;
  logic [63:0]                      word_out64;

  // Request decode: an enqueue works on the free-list head, a dequeue on the
  // queue head.
  always_comb begin
    req_q    = mqsb_pkg::queue_sel(req.queue_id);
    req_head = head_slot[req_q];
    req_tail = tail_slot[req_q];
    req_slot = (req.cmd == mqsb_pkg::CMD_ENQ) ? free_head : req_head;
    req_ok   = mqsb_pkg::is_slot(req_slot);
    req_idx  = req_slot[mqsb_pkg::SLOT_IDX_W-1:0];
  end

  // Link RAM write port: clearing pass, tail link on accept, or the link of
  // the moved slot on commit.
  always_comb begin
    link_wr_en   = 1'b0;
    link_wr_addr = '0;
    link_wr_data = '0;
    if (cmd.init_wr) begin
      link_wr_en   = 1'b1;
      link_wr_addr = init_cnt;
      link_wr_data = mqsb_pkg::SLOT_W'(init_cnt) + mqsb_pkg::SLOT_W'(1);
    end else if (cmd.accept && req.cmd == mqsb_pkg::CMD_ENQ && req_ok &&
                 mqsb_pkg::is_slot(req_head) && mqsb_pkg::is_slot(req_tail)) begin
      link_wr_en   = 1'b1;
      link_wr_addr = req_tail[mqsb_pkg::SLOT_IDX_W-1:0];
      link_wr_data = free_head;
    end else if (cmd.commit && cur_ok) begin
      link_wr_en   = 1'b1;
      link_wr_addr = cur_slot[mqsb_pkg::SLOT_IDX_W-1:0];
      link_wr_data = (cur_cmd == mqsb_pkg::CMD_ENQ) ? mqsb_pkg::NONE_SLOT : free_head;
    end
  end

  // Reads happen in the accept cycle; the data word is written then too.
  assign link_rd_en   = cmd.accept && req_ok;
  assign data_wr_en   = cmd.accept && req_ok && (req.cmd == mqsb_pkg::CMD_ENQ);
  assign data_rd_en   = cmd.accept && req_ok && (req.cmd == mqsb_pkg::CMD_DEQ);
  assign word_in64    = {32'd0, req.data_in};
  assign data_wr_word = word_in64[mqsb_pkg::DATA_WIDTH-1:0];
  assign word_out64   = 64'(data_rd_data);

  mqsb_ram #(
    .WIDTH (mqsb_pkg::SLOT_W),
    .DEPTH (mqsb_pkg::SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (link_rd_en),
    .rd_addr (req_idx),
    .rd_data (link_rd_data)
  );

  mqsb_ram #(
    .WIDTH (mqsb_pkg::DATA_WIDTH),
    .DEPTH (mqsb_pkg::SLOTS)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_wr_en),
    .wr_addr (req_idx),
    .wr_data (data_wr_word),
    .rd_en   (data_rd_en),
    .rd_addr (req_idx),
    .rd_data (data_rd_data)
  );

  // Clearing-pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
    end else if (cmd.init_wr) begin
      init_cnt <= init_cnt + mqsb_pkg::SLOT_IDX_W'(1);
    end
  end

  // Capture the request in flight.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_cmd  <= req.cmd;
      cur_q    <= req_q;
      cur_slot <= req_slot;
      cur_ok   <= req_ok;
    end
  end

  // Pointer update on commit of a successful request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
        head_slot[i] <= mqsb_pkg::NONE_SLOT;
        tail_slot[i] <= mqsb_pkg::NONE_SLOT;
      end
      free_head <= '0;
    end else if (cmd.commit && cur_ok) begin
      if (cur_cmd == mqsb_pkg::CMD_ENQ) begin
        free_head <= link_rd_data;
        if (!mqsb_pkg::is_slot(head_slot[cur_q])) begin
          head_slot[cur_q] <= cur_slot;
        end
        tail_slot[cur_q] <= cur_slot;
      end else begin
        head_slot[cur_q] <= link_rd_data;
        free_head        <= cur_slot;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.data_out <= (cur_cmd == mqsb_pkg::CMD_DEQ && cur_ok) ? word_out64[31:0] : 32'd0;
      if (cur_ok) begin
        rsp.status <= mqsb_pkg::ST_OK;
      end else if (cur_cmd == mqsb_pkg::CMD_ENQ) begin
        rsp.status <= mqsb_pkg::ST_FULL;
      end else begin
        rsp.status <= mqsb_pkg::ST_EMPTY;
      end
    end
  end

  // Status toward the controller.
  assign stat.init_last = (init_cnt == mqsb_pkg::SLOT_IDX_W'(mqsb_pkg::SLOTS - 1));
  assign stat.out_free  = !rsp_valid || rsp_ready;

`ifndef SYNTH
  // A commit always leaves a response waiting.
  a_commit_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit did not load the response register");

  // A successful enqueue leaves its queue non-empty.
  a_enq_fills_queue: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cur_ok && cur_cmd == mqsb_pkg::CMD_ENQ |=>
      mqsb_pkg::is_slot(head_slot[$past(cur_q)]))
    else $error("queue head empty after a successful enqueue");
`endif

endmodule

[hw/rtl/mqsb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_ctrl: sequencer for the multi-queue shared buffer
// Runs the free-list clearing pass after reset, then takes one request at a
// time through its read cycle and its commit step.
// ----------------------------------------------------------------------------
module mqsb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  mqsb_pkg::dp_status_t stat,
  output mqsb_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT   = 3'b001,
    S_IDLE   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  assign req_ready   = (state == S_IDLE);
  assign cmd.init_wr = (state == S_INIT);
  assign cmd.accept  = (state == S_IDLE) && req_valid;
  assign cmd.commit  = (state == S_FINISH) && stat.out_free;

`ifndef SYNTH
  // An accepted request is finished before another is taken.
  a_accept_to_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_FINISH)
    else $error("accepted request did not move to the commit step");

  // A commit returns the sequencer to idle.
  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == S_IDLE)
    else $error("commit did not return to idle");

  // The clearing pass never restarts outside reset.
  a_no_reinit: assert property (@(posedge clk) disable iff (rst)
    state != S_INIT |=> state != S_INIT)
    else $error("clearing pass restarted without reset");
`endif

endmodule

[bench/multi_queue_shared_buffer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_test: self-checking bench for the shared buffer
// Drives enqueue and dequeue requests with random gaps and receiver stalls.
// A software copy of the linked lists and the free list predicts every
// response. Responses are checked field by field, in order, as they leave.
// ----------------------------------------------------------------------------
import mqsb_pkg::*;

// Software copy of the slot store: per-queue head and tail, slot links, slot
// words and the free list. It predicts one response per accepted request.
class queue_store_model;
  typedef logic [SLOT_W-1:0] slot_t;

  slot_t                 head_of[QUEUES];
  slot_t                 tail_of[QUEUES];
  slot_t                 next_of[SLOTS];
  logic [DATA_WIDTH-1:0] word_of[SLOTS];
  slot_t                 free_first;
  rsp_t                  expected_rsp[$];
  int                    errors;
  int                    n_enq_ok;
  int                    n_full;
  int                    n_deq_ok;
  int                    n_empty;
  int                    n_checked;

  // After reset every queue is empty and all slots are chained in order.
  function new();
    for (int q = 0; q < QUEUES; q++) begin
      head_of[q] = NONE_SLOT;
      tail_of[q] = NONE_SLOT;
    end
    for (int s = 0; s < SLOTS; s++) begin
      next_of[s] = slot_t'(s + 1);
      word_of[s] = '0;
    end
    next_of[SLOTS-1] = NONE_SLOT;
    free_first = '0;
  endfunction

  function int pending();
    return expected_rsp.size();
  endfunction

  // Apply one accepted request to the copy and queue its response.
  function void note_request(input req_t r);
    rsp_t  e;
    int    q;
    slot_t s;
    e.data_out = '0;
    e.status   = ST_OK;
    q = int'(r.queue_id) % QUEUES;
    if (r.cmd == CMD_ENQ) begin
      s = free_first;
      if (s >= SLOTS) begin
        e.status = ST_FULL;
        n_full++;
      end else begin
        free_first = next_of[s];
        // An empty queue takes the slot as its head; otherwise it is linked
        // after the tail. A stale tail of an emptied queue is never followed.
        if (head_of[q] >= SLOTS) begin
          head_of[q] = s;
        end else if (tail_of[q] < SLOTS) begin
          next_of[tail_of[q]] = s;
        end
        next_of[s] = NONE_SLOT;
        tail_of[q] = s;
        word_of[s] = r.data_in;
        n_enq_ok++;
      end
    end else begin
      s = head_of[q];
      if (s >= SLOTS) begin
        e.status = ST_EMPTY;
        n_empty++;
      end else begin
        // The freed slot goes to the front of the free list.
        head_of[q] = next_of[s];
        next_of[s] = free_first;
        free_first = s;
        e.data_out = word_of[s];
        n_deq_ok++;
      end
    end
    expected_rsp.push_back(e);
  endfunction

  task report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Compare one accepted response with the oldest prediction.
  task check_response(input rsp_t got);
    rsp_t e;
    if (expected_rsp.size() == 0) begin
      report_mismatch($sformatf("response with no request pending (status %0d)",
                                got.status));
    end else begin
      e = expected_rsp.pop_front();
      n_checked++;
      if (got.status !== e.status) begin
        report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                  n_checked, got.status, e.status));
      end
      if (got.data_out !== e.data_out) begin
        report_mismatch($sformatf("response %0d data_out %h, expected %h",
                                  n_checked, got.data_out, e.data_out));
      end
    end
  endtask
endclass

module multi_queue_shared_buffer_test;

  localparam int RANDOM_REQUESTS = 1730;
  localparam int IDLE_PCT        = 27;
  localparam int STALL_AFTER     = 300;
  localparam int STALL_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  queue_store_model store_model;
  int   n_sent = 0;
  int   rsp_count = 0;
  int   quiet_cycles = 0;
  bit   stall_done = 1'b0;
  logic calm;

  multi_queue_shared_buffer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // A stretch of requests during which neither side idles.
  assign calm = (n_sent >= 600) && (n_sent < 900);

  // Watch both channels at the rising edge; also the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        store_model.check_response(rsp);
        rsp_count++;
      end
      if (req_valid && req_ready) begin
        store_model.note_request(req);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no request or response moved for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the store backs up.
  initial begin
    forever begin
      @(negedge clk);
      if (!stall_done && rsp_count >= STALL_AFTER) begin
        stall_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk);
      end else begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request, with random gaps before it, and wait until it is taken.
  task automatic send_req(input logic cmd, input int q, input logic [31:0] word);
    req_t r;
    r.cmd      = cmd;
    r.queue_id = q[1:0];
    r.data_in  = word;
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic enq(input int q, input logic [31:0] word);
    send_req(CMD_ENQ, q, word);
  endtask

  task automatic deq(input int q);
    send_req(CMD_DEQ, q, $urandom);
  endtask

  // Main sequence: reset, directed requests, random traffic, drain, verdict.
  initial begin
    int enq_pct;
    store_model = new();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Dequeue from an empty queue, then the data extremes into each queue.
    deq(0);
    enq(0, 32'h7fff_ffff);
    enq(1, 32'h8000_0000);
    enq(2, 32'hffff_ffff);
    enq(3, 32'h0000_0000);
    // Fill the rest of the store, then one enqueue that finds it full.
    for (int i = 0; i < SLOTS - 4; i++) begin
      enq(i % QUEUES, (i % 2 == 0) ? 32'haaaa_aaaa : 32'h5555_5555);
    end
    enq(1, 32'h1234_5678);
    // Dequeue once from each queue to free slots, then reuse one in queue 0.
    deq(0);
    deq(1);
    deq(2);
    deq(3);
    enq(0, 32'hdead_beef);
    deq(0);

    // Random traffic in blocks that lean toward filling or draining the store, or neither.
    enq_pct = 50;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 15;
          1: enq_pct = 50;
          2: enq_pct = 65;
          default: enq_pct = 85;
        endcase
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        enq($urandom_range(0, QUEUES - 1), $urandom);
      end else begin
        deq($urandom_range(0, QUEUES - 1));
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (store_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d enqueues stored, %0d refused as full,",
             n_sent, store_model.n_enq_ok, store_model.n_full);
    $display("%0d dequeues returned a word, %0d found the queue empty; %0d mismatches.",
             store_model.n_deq_ok, store_model.n_empty, store_model.errors);
    if (store_model.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
